@@ design/ids_pkg.sv @@
// Shared types and constants for the interrupt dispatch sequencer.
`default_nettype none

package ids_pkg;

  localparam int unsigned NumSources = 5;
  localparam int unsigned AddrW      = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;

  // Position of each machine cycle inside the five-step entry sequence.
  typedef enum logic [2:0] {
    PHASE_ONE   = 3'd0,
    PHASE_TWO   = 3'd1,
    PHASE_PUSHH = 3'd2,
    PHASE_PUSHL = 3'd3,
    PHASE_JUMP  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    SRC_VBLANK = 3'd0,
    SRC_STAT   = 3'd1,
    SRC_TIMER  = 3'd2,
    SRC_SERIAL = 3'd3,
    SRC_JOYPAD = 3'd4
  } source_e;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegVecVblank = 3'd0;
  localparam logic [CfgIdxW-1:0] RegVecStat   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegVecTimer  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegVecSerial = 3'd3;
  localparam logic [CfgIdxW-1:0] RegVecJoypad = 3'd4;

  localparam logic [NumSources-1:0][AddrW-1:0] VectorReset = {
    16'h0060, 16'h0058, 16'h0050, 16'h0048, 16'h0040
  };

  localparam logic [ByteW-1:0] MaskVblank = 8'h01;
  localparam logic [ByteW-1:0] MaskStat   = 8'h02;
  localparam logic [ByteW-1:0] MaskTimer  = 8'h04;
  localparam logic [ByteW-1:0] MaskSerial = 8'h08;
  localparam logic [ByteW-1:0] MaskJoypad = 8'h10;

  typedef struct packed {
    logic [AddrW-1:0] prog_counter;
    logic [AddrW-1:0] stack_ptr;
    logic [ByteW-1:0] enable_mask;
    logic [ByteW-1:0] flag_mask;
  } item_t;

  typedef struct packed {
    logic             mem_write_valid;
    logic [AddrW-1:0] mem_write_addr;
    logic [ByteW-1:0] mem_write_data;
    logic [AddrW-1:0] stack_ptr_out;
    logic [AddrW-1:0] prog_counter_out;
    logic             flag_write_valid;
    logic [ByteW-1:0] flag_mask_out;
    logic [2:0]       source_taken;
    logic             master_enable_clear;
    logic             sequence_done;
  } result_t;

endpackage

`default_nettype wire

@@ design/ids_if.sv @@
// Valid/ready stream interfaces for the sequencer's input and result channels.
`default_nettype none

interface ids_in_if;
  logic          valid;
  logic          ready;
  ids_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ids_out_if;
  logic            valid;
  logic            ready;
  ids_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/ids_step.sv @@
// Combinational work of one machine cycle of the interrupt entry sequence.
`default_nettype none

module ids_step (
  input  ids_pkg::phase_e                                          phase_i,
  input  ids_pkg::item_t                                           item_i,
  input  logic [ids_pkg::NumSources-1:0][ids_pkg::AddrW-1:0]       vectors_i,
  output ids_pkg::result_t                                         result_o
);

  logic [ids_pkg::AddrW-1:0] sp_dec;
  logic [ids_pkg::ByteW-1:0] pending;
  ids_pkg::source_e          src;
  logic [ids_pkg::ByteW-1:0] clear_mask;

  assign sp_dec  = item_i.stack_ptr - 16'd1;
  assign pending = item_i.enable_mask & item_i.flag_mask;

  // Joypad also serves as the fallback when nothing is pending.
  always_comb begin
    priority if ((pending & ids_pkg::MaskVblank) != '0) begin
      src        = ids_pkg::SRC_VBLANK;
      clear_mask = ids_pkg::MaskVblank;
    end else if ((pending & ids_pkg::MaskStat) != '0) begin
      src        = ids_pkg::SRC_STAT;
      clear_mask = ids_pkg::MaskStat;
    end else if ((pending & ids_pkg::MaskTimer) != '0) begin
      src        = ids_pkg::SRC_TIMER;
      clear_mask = ids_pkg::MaskTimer;
    end else if ((pending & ids_pkg::MaskSerial) != '0) begin
      src        = ids_pkg::SRC_SERIAL;
      clear_mask = ids_pkg::MaskSerial;
    end else begin
      src        = ids_pkg::SRC_JOYPAD;
      clear_mask = ids_pkg::MaskJoypad;
    end
  end

  always_comb begin
    result_o                     = '0;
    result_o.stack_ptr_out       = item_i.stack_ptr;
    result_o.prog_counter_out    = item_i.prog_counter;
    result_o.flag_mask_out       = item_i.flag_mask;
    unique case (phase_i)
      ids_pkg::PHASE_PUSHH: begin
        result_o.mem_write_valid = 1'b1;
        result_o.mem_write_addr  = sp_dec;
        result_o.mem_write_data  = item_i.prog_counter[15:8];
        result_o.stack_ptr_out   = sp_dec;
      end
      ids_pkg::PHASE_PUSHL: begin
        result_o.mem_write_valid = 1'b1;
        result_o.mem_write_addr  = sp_dec;
        result_o.mem_write_data  = item_i.prog_counter[7:0];
        result_o.stack_ptr_out   = sp_dec;
      end
      ids_pkg::PHASE_JUMP: begin
        result_o.prog_counter_out    = vectors_i[src];
        result_o.flag_write_valid    = 1'b1;
        result_o.flag_mask_out       = item_i.flag_mask & ~clear_mask;
        result_o.source_taken        = src;
        result_o.master_enable_clear = 1'b1;
        result_o.sequence_done       = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/interrupt_dispatch_sequencer.sv @@
// Top level of the interrupt dispatch sequencer: step counter, vectors, two-stage pipeline.
//
//   channel   direction  handshake      payload
//   in_i      sink       valid/ready    ids_pkg::item_t, one machine cycle
//   out_o     source     valid/ready    ids_pkg::result_t, one result per item
//   cfg       write      cfg_we_i       cfg_idx_i selects a jump vector, cfg_data_i
//
// One item per clock is accepted and delivered while results are not stalled; each item passes
// through the input register, then the result register.
// The step counter advances at each input transaction, so steps stay in order under stalls.
// Reset puts the counter at step one and loads the default vectors.
// A stalled result holds in the result register while the input register keeps one more item.
`default_nettype none

module interrupt_dispatch_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ids_in_if.sink                          in_i,
  ids_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [ids_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ids_pkg::CfgDataW-1:0]    cfg_data_i
);

  ids_pkg::phase_e phase_q, phase_d;

  logic [ids_pkg::NumSources-1:0][ids_pkg::AddrW-1:0] vec_q;

  logic             s1_valid_q;
  ids_pkg::item_t   s1_item_q;
  ids_pkg::phase_e  s1_phase_q;
  logic             out_valid_q;
  ids_pkg::result_t out_result_q;
  ids_pkg::result_t step_result;

  logic out_load;
  logic in_fire;

  assign out_load   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || out_load;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    unique case (phase_q)
      ids_pkg::PHASE_ONE:   phase_d = ids_pkg::PHASE_TWO;
      ids_pkg::PHASE_TWO:   phase_d = ids_pkg::PHASE_PUSHH;
      ids_pkg::PHASE_PUSHH: phase_d = ids_pkg::PHASE_PUSHL;
      ids_pkg::PHASE_PUSHL: phase_d = ids_pkg::PHASE_JUMP;
      ids_pkg::PHASE_JUMP:  phase_d = ids_pkg::PHASE_ONE;
      default:              phase_d = ids_pkg::PHASE_TWO;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ids_pkg::PHASE_ONE;
    end else if (in_fire) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q <= ids_pkg::VectorReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ids_pkg::RegVecVblank: vec_q[ids_pkg::SRC_VBLANK] <= cfg_data_i;
        ids_pkg::RegVecStat:   vec_q[ids_pkg::SRC_STAT]   <= cfg_data_i;
        ids_pkg::RegVecTimer:  vec_q[ids_pkg::SRC_TIMER]  <= cfg_data_i;
        ids_pkg::RegVecSerial: vec_q[ids_pkg::SRC_SERIAL] <= cfg_data_i;
        ids_pkg::RegVecJoypad: vec_q[ids_pkg::SRC_JOYPAD] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q  <= in_i.data;
      s1_phase_q <= phase_q;
    end
  end

  ids_step u_step (
    .phase_i   (s1_phase_q),
    .item_i    (s1_item_q),
    .vectors_i (vec_q),
    .result_o  (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_result_q <= step_result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_result_q;

endmodule

`default_nettype wire

@@ design/ids_checker.sv @@
// Port-level assertions for the interrupt dispatch sequencer, bound to the top level.
`default_nettype none

module ids_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input ids_pkg::result_t out_data_i
);

  logic       out_fire;
  logic [2:0] out_count_q;

  assign out_fire = out_valid_i && out_ready_i;

  // Counts delivered results through the five steps of the sequence.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_count_q <= 3'd0;
    end else if (out_fire) begin
      out_count_q <= (out_count_q == 3'd4) ? 3'd0 : out_count_q + 3'd1;
    end
  end

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  a_done_on_fifth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> (out_data_i.sequence_done == (out_count_q == 3'd4)))
    else $error("sequence end not on the fifth result");

  a_push_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> (out_data_i.mem_write_valid ==
                  ((out_count_q == 3'd2) || (out_count_q == 3'd3))))
    else $error("stack write on the wrong step");

  a_jump_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_data_i.sequence_done |->
      out_data_i.flag_write_valid && out_data_i.master_enable_clear &&
      !out_data_i.mem_write_valid && (out_data_i.source_taken <= 3'd4))
    else $error("inconsistent dispatch result");

  a_push_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_data_i.mem_write_valid |->
      out_data_i.mem_write_addr == out_data_i.stack_ptr_out)
    else $error("stack write address differs from new stack pointer");

endmodule

bind interrupt_dispatch_sequencer ids_checker u_ids_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire

@@ test/dispatch_checker.sv @@
// Watches the sequencer channels, predicts each result and compares it field by field.
module dispatch_checker
  import ids_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  ids_in_if                   in_i,
  ids_out_if                  out_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  mismatch_cnt_o,
  output int                  pending_cnt_o,
  output int                  checked_cnt_o,
  output int                  dispatch_cnt_o
);

  logic [NumSources-1:0][AddrW-1:0] jump_vectors;
  phase_e                           entry_phase;
  result_t                          expected_results[$];
  result_t                          want;
  bit                               bad;

  // A step value past the last one behaves as step one, so it moves on to step two.
  function automatic phase_e advance_phase(input phase_e ph);
    case (ph)
      PHASE_ONE:   return PHASE_TWO;
      PHASE_TWO:   return PHASE_PUSHH;
      PHASE_PUSHH: return PHASE_PUSHL;
      PHASE_PUSHL: return PHASE_JUMP;
      PHASE_JUMP:  return PHASE_ONE;
      default:     return PHASE_TWO;
    endcase
  endfunction

  function automatic result_t predict_cycle(input item_t it, input phase_e ph,
                                            input logic [NumSources-1:0][AddrW-1:0] vecs);
    result_t          r;
    logic [AddrW-1:0] sp_dec;
    logic [ByteW-1:0] pending;
    source_e          src;
    r                  = '0;
    sp_dec             = it.stack_ptr - 16'd1;
    r.stack_ptr_out    = it.stack_ptr;
    r.prog_counter_out = it.prog_counter;
    r.flag_mask_out    = it.flag_mask;
    case (ph)
      PHASE_PUSHH, PHASE_PUSHL: begin
        r.mem_write_valid = 1'b1;
        r.mem_write_addr  = sp_dec;
        r.mem_write_data  = (ph == PHASE_PUSHH) ? it.prog_counter[15:8] : it.prog_counter[7:0];
        r.stack_ptr_out   = sp_dec;
      end
      PHASE_JUMP: begin
        pending = it.enable_mask & it.flag_mask;
        // Checked from lowest priority up so the highest pending source wins;
        // joypad is the fallback even when nothing is pending.
        src = SRC_JOYPAD;
        if ((pending & MaskSerial) != '0) src = SRC_SERIAL;
        if ((pending & MaskTimer) != '0)  src = SRC_TIMER;
        if ((pending & MaskStat) != '0)   src = SRC_STAT;
        if ((pending & MaskVblank) != '0) src = SRC_VBLANK;
        r.prog_counter_out    = vecs[src];
        r.flag_write_valid    = 1'b1;
        r.flag_mask_out       = it.flag_mask & ~(MaskVblank << src);
        r.source_taken        = src;
        r.master_enable_clear = 1'b1;
        r.sequence_done       = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [15:0] exp_v,
                             input logic [15:0] act_v, inout bit is_bad);
    if (exp_v !== act_v) begin
      if (!is_bad && mismatch_cnt_o < 10)
        $display("Mismatch on result %0d:", checked_cnt_o);
      if (mismatch_cnt_o < 10)
        $display("  %s expected %h, got %h", fname, exp_v, act_v);
      is_bad = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_vectors = VectorReset;
      entry_phase  = PHASE_ONE;
      expected_results.delete();
      pending_cnt_o = 0;
    end else begin
      if (cfg_we_i && cfg_idx_i < NumSources)
        jump_vectors[cfg_idx_i] = cfg_data_i;
      if (in_i.valid && in_i.ready) begin
        expected_results.push_back(predict_cycle(in_i.data, entry_phase, jump_vectors));
        entry_phase = advance_phase(entry_phase);
      end
      if (out_i.valid && out_i.ready) begin
        if (expected_results.size() == 0) begin
          if (mismatch_cnt_o < 10)
            $display("Result transaction with no expectation pending: %p", out_i.data);
          mismatch_cnt_o++;
        end else begin
          want = expected_results.pop_front();
          bad  = 1'b0;
          check_field("mem_write_valid", want.mem_write_valid, out_i.data.mem_write_valid, bad);
          check_field("mem_write_addr", want.mem_write_addr, out_i.data.mem_write_addr, bad);
          check_field("mem_write_data", want.mem_write_data, out_i.data.mem_write_data, bad);
          check_field("stack_ptr_out", want.stack_ptr_out, out_i.data.stack_ptr_out, bad);
          check_field("prog_counter_out", want.prog_counter_out,
                      out_i.data.prog_counter_out, bad);
          check_field("flag_write_valid", want.flag_write_valid,
                      out_i.data.flag_write_valid, bad);
          check_field("flag_mask_out", want.flag_mask_out, out_i.data.flag_mask_out, bad);
          check_field("source_taken", want.source_taken, out_i.data.source_taken, bad);
          check_field("master_enable_clear", want.master_enable_clear,
                      out_i.data.master_enable_clear, bad);
          check_field("sequence_done", want.sequence_done, out_i.data.sequence_done, bad);
          if (bad) mismatch_cnt_o++;
          if (want.sequence_done) dispatch_cnt_o++;
          checked_cnt_o++;
        end
      end
      pending_cnt_o = expected_results.size();
    end
  end

endmodule

@@ test/interrupt_dispatch_sequencer_test.sv @@
// Stimulus, handshake timing and final verdict for the interrupt dispatch sequencer.
module interrupt_dispatch_sequencer_test;
  import ids_pkg::*;

  localparam int unsigned NumPhases      = 5;
  localparam int unsigned RandomPerPhase = 90;
  localparam int unsigned HoldCycles     = 40;
  localparam int unsigned SettleCycles   = 8;
  // Longest correct quiet stretch is the receiver hold-off; this leaves ample margin.
  localparam int unsigned WatchdogLimit  = 2000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  ids_in_if  in_ch ();
  ids_out_if out_ch ();

  bit idle_on;
  bit hold_req;
  int hold_cnt;
  int directed_cnt;
  int random_cnt;
  int setting_cnt;
  int quiet_cycles;
  int mismatch_cnt;
  int pending_cnt;
  int checked_cnt;
  int dispatch_cnt;

  interrupt_dispatch_sequencer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  dispatch_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_ch),
    .out_i          (out_ch),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt),
    .checked_cnt_o  (checked_cnt),
    .dispatch_cnt_o (dispatch_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.prog_counter = pick_word();
    it.stack_ptr    = pick_word();
    it.enable_mask  = 8'($urandom);
    it.flag_mask    = 8'($urandom);
    // Clearing the low enable bits lets the lower-priority sources win as often.
    if ($urandom_range(0, 1) == 1)
      it.enable_mask &= ~((MaskVblank << $urandom_range(0, 4)) - 8'h01);
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
  endtask

  task automatic load_vectors(input logic [NumSources-1:0][AddrW-1:0] vecs);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegVecVblank;
    cfg_data_i <= vecs[SRC_VBLANK];
    @(negedge clk_i);
    cfg_idx_i  <= RegVecStat;
    cfg_data_i <= vecs[SRC_STAT];
    @(negedge clk_i);
    cfg_idx_i  <= RegVecTimer;
    cfg_data_i <= vecs[SRC_TIMER];
    @(negedge clk_i);
    cfg_idx_i  <= RegVecSerial;
    cfg_data_i <= vecs[SRC_SERIAL];
    @(negedge clk_i);
    cfg_idx_i  <= RegVecJoypad;
    cfg_data_i <= vecs[SRC_JOYPAD];
    @(negedge clk_i);
    // An index past the last vector must leave every vector alone.
    cfg_idx_i  <= CfgIdxW'(NumSources + $urandom_range(0, 2));
    cfg_data_i <= 16'($urandom);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    setting_cnt++;
  endtask

  // Five full sequences at the reset vectors: field extremes, stack wrap, ignored
  // upper mask bits, nothing pending, and several priority picks.
  task automatic run_directed();
    logic [4:0][15:0] pc_set = {16'h1234, 16'h8000, 16'h00FF, 16'h0000, 16'hFFFF};
    logic [4:0][15:0] sp_set = {16'h8000, 16'h0001, 16'hFFFF, 16'h0001, 16'h0000};
    logic [4:0][7:0]  ie_set = {8'h18, 8'h1E, 8'h00, 8'hE0, 8'hFF};
    logic [4:0][7:0]  if_set = {8'h1F, 8'h16, 8'h00, 8'hFF, 8'hFF};
    item_t            it;
    for (int s = 0; s < 5; s++) begin
      for (int k = 0; k < 5; k++) begin
        it.prog_counter = pc_set[s];
        it.stack_ptr    = sp_set[s];
        it.enable_mask  = (k == int'(PHASE_JUMP)) ? ie_set[s] : 8'($urandom);
        it.flag_mask    = (k == int'(PHASE_JUMP)) ? if_set[s] : 8'($urandom);
        send_item(it);
        directed_cnt++;
      end
    end
  endtask

  initial begin
    logic [NumSources-1:0][AddrW-1:0] vecs;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    setting_cnt = 1;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       vecs = {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
        1:       vecs = {16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
        default: for (int i = 0; i < NumSources; i++) vecs[i] = 16'($urandom);
      endcase
      load_vectors(vecs);
      // Two phases run with no idling at all, one of them with a long result stall, so
      // the input side backs up while items keep being offered.
      idle_on = (p != 2) && (p != 4);
      if (p == 2) hold_req = 1'b1;
      for (int n = 0; n < RandomPerPhase; n++) begin
        send_item(random_item());
        random_cnt++;
      end
      drain();
    end

    repeat (SettleCycles) @(negedge clk_i);
    $display("Covered %0d directed and %0d random transactions over %0d vector settings,",
             directed_cnt, random_cnt, setting_cnt);
    $display("with %0d results checked, %0d dispatches and %0d long result stalls.",
             checked_cnt, dispatch_cnt, hold_cnt);
    if (mismatch_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        stall = HoldCycles;
        hold_cnt++;
      end else begin
        stall = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      hold_req = 1'b0;
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Timeout: no transaction for %0d cycles, %0d results outstanding.",
               quiet_cycles, pending_cnt);
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
